@@ sv/mh64_pkg.sv @@
// ---------------------------------------------------------------------------
// mh64_pkg: shared types and constants for the MurmurHash64A hash unit
// Holds the multiplier constant, the shift amount and the command struct
// that the controller sends to the datapath.
// ---------------------------------------------------------------------------
`default_nettype none

package mh64_pkg;

    localparam logic [63:0] MUR_M    = 64'hc6a4a7935bd1e995;
    localparam logic [31:0] MUR_M_LO = MUR_M[31:0];
    localparam logic [31:0] MUR_M_HI = MUR_M[63:32];
    localparam int unsigned MUR_R    = 47;

    // Multiply jobs, one-hot so the pending set picks its lowest bit directly
    typedef enum logic [4:0] {
        OP_INIT = 5'b00001,
        OP_MIX1 = 5'b00010,
        OP_MIX2 = 5'b00100,
        OP_HMUL = 5'b01000,
        OP_FIN  = 5'b10000
    } t_mul_op;

    // Source of the multiplier operand
    typedef enum logic [2:0] {
        SEL_LEN    = 3'd0,
        SEL_WORD   = 3'd1,
        SEL_MIX    = 3'd2,
        SEL_H_ACC  = 3'd3,
        SEL_H_TAIL = 3'd4,
        SEL_H_FIN  = 3'd5
    } t_opsel;

    // Update of the running hash when a product completes
    typedef enum logic [1:0] {
        POST_NONE = 2'd0,
        POST_SEED = 2'd1,
        POST_SET  = 2'd2,
        POST_FIN  = 2'd3
    } t_post;

    typedef struct packed {
        logic       capture;
        logic       load_op;
        t_opsel     opsel;
        logic       mul_en;
        logic [1:0] mul_step;
        t_post      post;
        logic       load_out;
    } t_dp_cmd;

endpackage

`default_nettype wire

@@ sv/mh64_datapath.sv @@
// ---------------------------------------------------------------------------
// mh64_datapath: hash registers and shared 32x32 multiplier
// Forms each 64-bit product modulo 2^64 with the constant over four steps
// and applies the hash update that the controller commands.
// ---------------------------------------------------------------------------
`default_nettype none

module mh64_datapath (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_wr_en,
    input  wire logic [63:0]       i_cfg_wr_data,
    input  wire logic [63:0]       i_data_word,
    input  wire logic [3:0]        i_valid_bytes,
    input  wire logic [31:0]       i_string_length,
    input  wire mh64_pkg::t_dp_cmd i_cmd,
    output      logic [63:0]       o_hash_value
);
    import mh64_pkg::*;

    logic [63:0] r_seed;
    logic [63:0] r_hash;
    logic [63:0] r_tail;
    logic [31:0] r_len;
    logic [63:0] r_mop;
    logic [63:0] r_prod;
    logic [63:0] r_acc;
    logic [63:0] r_out;

    logic [63:0] masked_word;
    logic [63:0] operand;
    logic [31:0] mul_x;
    logic [31:0] mul_y;
    logic [63:0] mul_p;
    logic [63:0] prod_sum;

    always_comb begin
        for (int b = 0; b < 8; b++) begin
            masked_word[8*b +: 8] = (4'(b) < i_valid_bytes) ? i_data_word[8*b +: 8] : 8'h00;
        end
    end

    always_comb begin
        unique case (i_cmd.opsel)
            SEL_LEN:    operand = {32'h0, r_len};
            SEL_WORD:   operand = r_tail;
            SEL_MIX:    operand = r_acc ^ (r_acc >> MUR_R);
            SEL_H_ACC:  operand = r_hash ^ r_acc;
            SEL_H_TAIL: operand = r_hash ^ r_tail;
            SEL_H_FIN:  operand = r_hash ^ (r_hash >> MUR_R);
            default:    operand = '0;
        endcase
    end

    // low x low, then the two cross terms shifted up; the high x high term falls off
    assign mul_x    = (i_cmd.mul_step == 2'd2) ? r_mop[63:32] : r_mop[31:0];
    assign mul_y    = (i_cmd.mul_step == 2'd1) ? MUR_M_HI : MUR_M_LO;
    assign mul_p    = {32'h0, mul_x} * {32'h0, mul_y};
    assign prod_sum = r_acc + r_prod;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_tail <= masked_word;
            r_len  <= i_string_length;
        end
        if (i_cmd.load_op) begin
            r_mop <= operand;
        end
        if (i_cmd.mul_en) begin
            unique case (i_cmd.mul_step)
                2'd0: r_prod <= mul_p;
                2'd1: begin
                    r_acc  <= r_prod;
                    r_prod <= {mul_p[31:0], 32'h0};
                end
                2'd2: begin
                    r_acc  <= prod_sum;
                    r_prod <= {mul_p[31:0], 32'h0};
                end
                2'd3: r_acc <= prod_sum;
            endcase
        end
        if (i_cmd.load_out) begin
            r_out <= r_hash;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= '0;
            r_hash <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_seed <= i_cfg_wr_data;
            end
            unique case (i_cmd.post)
                POST_NONE: ;
                POST_SEED: r_hash <= r_seed ^ prod_sum;
                POST_SET:  r_hash <= prod_sum;
                POST_FIN:  r_hash <= prod_sum ^ (prod_sum >> MUR_R);
            endcase
        end
    end

    assign o_hash_value = r_out;

endmodule

`default_nettype wire

@@ sv/mh64_ctrl.sv @@
// ---------------------------------------------------------------------------
// mh64_ctrl: sequencer for the MurmurHash64A hash unit
// Tracks the multiply jobs that a word needs, steps the shared multiplier
// and owns both handshakes.
// ---------------------------------------------------------------------------
`default_nettype none

module mh64_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output      logic              o_stall,
    input  wire logic [3:0]        i_valid_bytes,
    input  wire logic              i_first_word,
    input  wire logic              i_last_word,
    output      logic              o_valid,
    input  wire logic              i_stall,
    output      mh64_pkg::t_dp_cmd o_cmd
);
    import mh64_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_LOAD = 7'b0000010,
        S_MUL0 = 7'b0000100,
        S_MUL1 = 7'b0001000,
        S_MUL2 = 7'b0010000,
        S_MUL3 = 7'b0100000,
        S_EMIT = 7'b1000000
    } t_state;

    t_state      r_state;
    t_state      n_state;
    logic [4:0]  r_pend;
    logic [4:0]  n_pend;
    logic        r_full;
    logic        r_last;
    logic        r_out_valid;

    logic        accept;
    logic        out_free;
    logic [4:0]  accept_pend;
    logic [4:0]  rest_pend;
    t_mul_op     op;

    assign accept   = i_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_stall;

    assign accept_pend = {i_last_word, (|i_valid_bytes), i_valid_bytes[3],
                          i_valid_bytes[3], i_first_word};

    // lowest pending job runs next
    assign op        = t_mul_op'(r_pend & (~r_pend + 5'd1));
    assign rest_pend = r_pend & ~op;

    always_comb begin
        n_state = r_state;
        n_pend  = r_pend;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_pend  = accept_pend;
                    n_state = (|accept_pend) ? S_LOAD : S_IDLE;
                end
            end
            S_LOAD: n_state = S_MUL0;
            S_MUL0: n_state = S_MUL1;
            S_MUL1: n_state = S_MUL2;
            S_MUL2: n_state = S_MUL3;
            S_MUL3: begin
                n_pend = rest_pend;
                if (|rest_pend) begin
                    n_state = S_LOAD;
                end else if (r_last) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.opsel    = SEL_LEN;
        o_cmd.post     = POST_NONE;
        o_cmd.capture  = accept;
        o_cmd.load_out = (r_state == S_EMIT) && out_free;
        unique case (r_state)
            S_LOAD: begin
                o_cmd.load_op = 1'b1;
                unique case (op)
                    OP_INIT: o_cmd.opsel = SEL_LEN;
                    OP_MIX1: o_cmd.opsel = SEL_WORD;
                    OP_MIX2: o_cmd.opsel = SEL_MIX;
                    OP_HMUL: o_cmd.opsel = r_full ? SEL_H_ACC : SEL_H_TAIL;
                    OP_FIN:  o_cmd.opsel = SEL_H_FIN;
                    default: o_cmd.opsel = SEL_LEN;
                endcase
            end
            S_MUL0: begin
                o_cmd.mul_en   = 1'b1;
                o_cmd.mul_step = 2'd0;
            end
            S_MUL1: begin
                o_cmd.mul_en   = 1'b1;
                o_cmd.mul_step = 2'd1;
            end
            S_MUL2: begin
                o_cmd.mul_en   = 1'b1;
                o_cmd.mul_step = 2'd2;
            end
            S_MUL3: begin
                o_cmd.mul_en   = 1'b1;
                o_cmd.mul_step = 2'd3;
                unique case (op)
                    OP_INIT: o_cmd.post = POST_SEED;
                    OP_HMUL: o_cmd.post = POST_SET;
                    OP_FIN:  o_cmd.post = POST_FIN;
                    default: o_cmd.post = POST_NONE;
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pend      <= '0;
            r_full      <= 1'b0;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
            if (accept) begin
                r_full <= i_valid_bytes[3];
                r_last <= i_last_word;
            end
            if (o_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;

    // finalization multiply always leads to the emit step
    a_fin_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL3 && op == OP_FIN) |=> (r_state == S_EMIT))
        else $error("finalize did not lead to emit");

    // a pending result that is still stalled blocks the next one
    a_emit_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && r_out_valid && i_stall) |=> (r_state == S_EMIT))
        else $error("result overwritten while stalled");

    a_mix_chain1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend[1] |-> (r_pend[2] && r_pend[3]))
        else $error("first mix without the rest of the word chain");

    a_mix_chain2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend[2] |-> r_pend[3])
        else $error("second mix without hash fold");

    a_busy_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD) |=> (r_state == S_MUL0 && $stable(r_pend)))
        else $error("multiply sequence broken");

endmodule

`default_nettype wire

@@ sv/murmur64a_string_hash_unit.sv @@
// ---------------------------------------------------------------------------
// murmur64a_string_hash_unit: MurmurHash64A over a word stream
// Sequence: a word is accepted while idle, then each 64-bit multiply (0 to 5
//   per word) runs a load step and then its multiply steps, and a last word
//   ends in an emit step. A new word is taken only once the last one is through,
//   as the single shared 32x32 multiplier forms each product in four steps; the
//   emit step repeats while an earlier hash is still stalled at the output.
// Reset: synchronous, clears the seed and the running hash to zero.
// ---------------------------------------------------------------------------
`default_nettype none

module murmur64a_string_hash_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [63:0] i_cfg_wr_data,
    input  wire logic        i_valid,
    output      logic        o_stall,
    input  wire logic [63:0] i_data_word,
    input  wire logic [3:0]  i_valid_bytes,
    input  wire logic        i_first_word,
    input  wire logic        i_last_word,
    input  wire logic [31:0] i_string_length,
    output      logic        o_valid,
    input  wire logic        i_stall,
    output      logic [63:0] o_hash_value
);
    import mh64_pkg::*;

    t_dp_cmd cmd;

    mh64_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_valid_bytes (i_valid_bytes),
        .i_first_word  (i_first_word),
        .i_last_word   (i_last_word),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_cmd         (cmd)
    );

    mh64_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_data_word     (i_data_word),
        .i_valid_bytes   (i_valid_bytes),
        .i_string_length (i_string_length),
        .i_cmd           (cmd),
        .o_hash_value    (o_hash_value)
    );

endmodule

`default_nettype wire

@@ dv/tb_murmur64a_string_hash_unit.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_murmur64a_string_hash_unit: self-checking bench for the string hash unit
// A short table of directed words runs first. Random strings follow, mostly
// well formed with some stray words, under several seeds. Each transaction
// accepted on the input updates a local MurmurHash64A model. Every last word
// queues the hash it should produce. Hashes leaving the block are compared
// in order against that queue. Idle patterns change between phases, and a
// long output hold backs the block up until it stalls its input.
// ---------------------------------------------------------------------------

module tb_murmur64a_string_hash_unit;

    import mh64_pkg::*;

    localparam int DIRECTED_ROWS  = 24;
    localparam int WORDS_PER_SEG  = 258;
    localparam int RANDOM_SEGS    = 6;
    localparam int SETTLE_CYCLES  = 40;
    localparam int HOLD_CYCLES    = 600;
    localparam int WATCHDOG_LIMIT = 5000;

    typedef struct packed {
        logic [63:0] data;
        logic [3:0]  nvalid;
        logic        first;
        logic        last;
        logic [31:0] len;
    } t_hash_word;

    typedef struct packed {
        logic [63:0] data;
        logic [3:0]  nvalid;
        logic        first;
        logic        last;
        logic [31:0] len;
        logic        pinned;
        logic [63:0] pinned_hash;
    } t_directed_row;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_cfg_wr_en     = 1'b0;
    logic [63:0] i_cfg_wr_data   = '0;
    logic        i_valid         = 1'b0;
    logic        o_stall;
    logic [63:0] i_data_word     = '0;
    logic [3:0]  i_valid_bytes   = '0;
    logic        i_first_word    = 1'b0;
    logic        i_last_word     = 1'b0;
    logic [31:0] i_string_length = '0;
    logic        o_valid;
    logic        i_stall         = 1'b0;
    logic [63:0] o_hash_value;

    // model state
    logic [63:0] model_seed = '0;
    logic [63:0] model_hash = '0;
    logic [63:0] expected_hashes [$];

    int send_idle_pct   = 0;
    int recv_idle_pct   = 0;
    int hold_requests   = 0;
    int holds_started   = 0;
    int hold_left       = 0;
    int quiet_cycles    = 0;
    int words_sent      = 0;
    int hashes_checked  = 0;
    int mismatch_count  = 0;
    int seeds_written   = 0;

    t_directed_row directed_rows [DIRECTED_ROWS];

    murmur64a_string_hash_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_data_word     (i_data_word),
        .i_valid_bytes   (i_valid_bytes),
        .i_first_word    (i_first_word),
        .i_last_word     (i_last_word),
        .i_string_length (i_string_length),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_hash_value    (o_hash_value)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic logic [63:0] mix_key(input logic [63:0] k);
        logic [63:0] t;
        t = k * MUR_M;
        t = t ^ (t >> MUR_R);
        return t * MUR_M;
    endfunction

    // Advance the running hash by one word; report the hash on a last word
    task automatic fold_word(input t_hash_word w, output bit emits, output logic [63:0] digest);
        logic [63:0] h;
        logic [63:0] mask;
        h = model_hash;
        if (w.first)
            h = model_seed ^ ({32'd0, w.len} * MUR_M);
        if (w.nvalid >= 4'd8) begin
            h = h ^ mix_key(w.data);
            h = h * MUR_M;
        end else if (w.nvalid != 4'd0) begin
            mask = (64'd1 << (8 * w.nvalid)) - 64'd1;
            h = h ^ (w.data & mask);
            h = h * MUR_M;
        end
        emits = w.last;
        if (w.last) begin
            h = h ^ (h >> MUR_R);
            h = h * MUR_M;
            h = h ^ (h >> MUR_R);
        end
        model_hash = h;
        digest = h;
    endtask

    task automatic send_word(input t_hash_word w, input bit pinned = 1'b0,
                             input logic [63:0] pinned_hash = '0);
        bit          emits;
        logic [63:0] digest;
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            do begin
                @(posedge i_clk);
            end while ($urandom_range(99) < send_idle_pct);
        end
        i_valid         <= 1'b1;
        i_data_word     <= w.data;
        i_valid_bytes   <= w.nvalid;
        i_first_word    <= w.first;
        i_last_word     <= w.last;
        i_string_length <= w.len;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        fold_word(w, emits, digest);
        if (emits)
            expected_hashes.push_back(pinned ? pinned_hash : digest);
        words_sent++;
    endtask

    task automatic send_random_string();
        t_hash_word  w;
        int unsigned roll;
        int unsigned len;
        int unsigned nwords;
        logic [31:0] len_field;
        bit          empty_close;
        bit          truncated;
        roll = $urandom_range(99);
        if (roll < 12) begin
            // stray word with arbitrary control bits
            w.data   = {$urandom, $urandom};
            w.nvalid = 4'($urandom_range(15));
            w.first  = 1'($urandom_range(1));
            w.last   = 1'($urandom_range(1));
            w.len    = $urandom;
            send_word(w);
        end else begin
            len         = (roll < 17) ? $urandom_range(300) : $urandom_range(40);
            len_field   = ($urandom_range(9) == 0) ? 32'($urandom) : 32'(len);
            nwords      = (len == 0) ? 1 : (len + 7) / 8;
            empty_close = (len != 0) && (len % 8 == 0) && ($urandom_range(3) == 0);
            truncated   = ($urandom_range(19) == 0);
            for (int i = 0; i < nwords; i++) begin
                w.data  = {$urandom, $urandom};
                w.first = (i == 0);
                w.len   = (i == 0) ? len_field : 32'($urandom);
                if (i < nwords - 1)
                    w.nvalid = 4'd8;
                else if (len == 0)
                    w.nvalid = 4'd0;
                else
                    w.nvalid = (len % 8 == 0) ? 4'd8 : 4'(len % 8);
                w.last  = (i == nwords - 1) && !empty_close && !truncated;
                send_word(w);
            end
            if (empty_close) begin
                w.data   = {$urandom, $urandom};
                w.nvalid = 4'd0;
                w.first  = 1'b0;
                w.last   = 1'b1;
                w.len    = $urandom;
                send_word(w);
            end
        end
    endtask

    // Drop valid, wait for every hash, then let any trailing word finish
    task automatic drain_hashes();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_hashes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_seed(input logic [63:0] seed);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= seed;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        model_seed = seed;
        seeds_written++;
    endtask

    // Receiver: random stall, or a long hold when requested
    always @(posedge i_clk) begin
        if (hold_requests != holds_started) begin
            holds_started = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_hashes.size() == 0) begin
                $display("%0t: unexpected hash transaction, expected none, actual %h",
                         $time, o_hash_value);
                mismatch_count++;
            end else begin
                if (o_hash_value !== expected_hashes[0]) begin
                    $display("%0t: hash mismatch, expected %h, actual %h",
                             $time, expected_hashes[0], o_hash_value);
                    mismatch_count++;
                end
                void'(expected_hashes.pop_front());
                hashes_checked++;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
                $display("** murmur64a_string_hash_unit: FAILED **");
                $finish;
            end
        end
    end

    initial begin
        t_hash_word  w;
        logic [63:0] seed;
        int          target;
        directed_rows = '{
            // no first word after reset: running hash is still zero
            '{64'h0, 4'd0, 1'b0, 1'b1, 32'd0, 1'b1, 64'h0},
            // empty string under seed zero hashes to zero
            '{64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 1'b1, 1'b1, 32'd0, 1'b1, 64'h0},
            '{64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b1, 1'b1, 32'd8, 1'b0, 64'h0},
            '{64'h0, 4'd8, 1'b1, 1'b1, 32'd8, 1'b0, 64'h0},
            // counts above eight act as a full word
            '{64'h0123_4567_89AB_CDEF, 4'd15, 1'b1, 1'b1, 32'd8, 1'b0, 64'h0},
            '{64'hFEDC_BA98_7654_3210, 4'd9, 1'b1, 1'b1, 32'd8, 1'b0, 64'h0},
            // bytes past the valid count are ignored
            '{64'hFFFF_FFFF_FFFF_FFFF, 4'd1, 1'b1, 1'b1, 32'd1, 1'b0, 64'h0},
            '{64'hFFFF_FFFF_FFFF_FFFF, 4'd7, 1'b1, 1'b1, 32'd7, 1'b0, 64'h0},
            '{64'h8000_0000_0000_0001, 4'd4, 1'b1, 1'b1, 32'd4, 1'b0, 64'h0},
            '{64'h0123_4567_89AB_CDEF, 4'd8, 1'b1, 1'b0, 32'd16, 1'b0, 64'h0},
            '{64'hCAFE_F00D_DEAD_BEEF, 4'd8, 1'b0, 1'b1, 32'd0, 1'b0, 64'h0},
            // partial word in mid string
            '{64'h1122_3344_5566_7788, 4'd3, 1'b1, 1'b0, 32'd11, 1'b0, 64'h0},
            '{64'h99AA_BBCC_DDEE_FF00, 4'd8, 1'b0, 1'b1, 32'd0, 1'b0, 64'h0},
            // empty closing word
            '{64'h5A5A_5A5A_A5A5_A5A5, 4'd8, 1'b1, 1'b0, 32'd8, 1'b0, 64'h0},
            '{64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 1'b0, 1'b1, 32'd0, 1'b0, 64'h0},
            // length that disagrees with the words
            '{64'h0F0F_0F0F_F0F0_F0F0, 4'd5, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b0, 64'h0},
            '{64'h3C3C_3C3C_C3C3_C3C3, 4'd8, 1'b1, 1'b1, 32'd5, 1'b0, 64'h0},
            // continue from the finalized hash without a first word
            '{64'h7777_8888_9999_AAAA, 4'd8, 1'b0, 1'b1, 32'd0, 1'b0, 64'h0},
            // restart in mid string
            '{64'h1357_9BDF_2468_ACE0, 4'd8, 1'b1, 1'b0, 32'd10, 1'b0, 64'h0},
            '{64'hACE0_2468_9BDF_1357, 4'd2, 1'b1, 1'b1, 32'd2, 1'b0, 64'h0},
            '{64'hDEAD_0000_BEEF_0000, 4'd6, 1'b0, 1'b0, 32'hFFFF_FFFF, 1'b0, 64'h0},
            '{64'h0000_1111_2222_3333, 4'd0, 1'b0, 1'b1, 32'h0, 1'b0, 64'h0},
            '{64'h0, 4'd0, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b0, 64'h0},
            '{64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b0, 1'b1, 32'hFFFF_FFFF, 1'b0, 64'h0}
        };

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 34;
        recv_idle_pct <= 57;
        foreach (directed_rows[i]) begin
            w.data   = directed_rows[i].data;
            w.nvalid = directed_rows[i].nvalid;
            w.first  = directed_rows[i].first;
            w.last   = directed_rows[i].last;
            w.len    = directed_rows[i].len;
            send_word(w, directed_rows[i].pinned, directed_rows[i].pinned_hash);
        end

        for (int seg = 0; seg < RANDOM_SEGS; seg++) begin
            drain_hashes();
            case (seg)
                0:       seed = 64'hFFFF_FFFF_FFFF_FFFF;
                2:       seed = 64'h0;
                3:       seed = 64'h8000_0000_0000_0000;
                default: seed = {$urandom, $urandom};
            endcase
            write_seed(seed);
            if (seg < 2) begin
                send_idle_pct = 34;
                recv_idle_pct <= 57;
            end else if (seg < 4) begin
                send_idle_pct = 57;
                recv_idle_pct <= 34;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct <= 0;
            end
            // hold the output long enough to back up the input
            if (seg == RANDOM_SEGS - 1)
                hold_requests++;
            target = words_sent + WORDS_PER_SEG;
            while (words_sent < target) send_random_string();
        end
        drain_hashes();

        $display("Covered %0d input words and %0d hashes across %0d seed settings,",
                 words_sent, hashes_checked, seeds_written + 1);
        $display("with shifting idle patterns and one long output hold.");
        if (mismatch_count == 0) begin
            $display("** murmur64a_string_hash_unit: PASSED **");
        end else begin
            $display("** murmur64a_string_hash_unit: FAILED **");
        end
        $finish;
    end

endmodule
